### design/directed_graph_cycle_detect_unit_macros.svh
// Assertion macros for the directed graph cycle detect unit.
`ifndef DIRECTED_GRAPH_CYCLE_DETECT_UNIT_MACROS_SVH
`define DIRECTED_GRAPH_CYCLE_DETECT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define DGCD_ASSERT_IMPLY(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("dgcd assertion failed");
// Next-cycle implication, sampled on clk, off during reset.
`define DGCD_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("dgcd assertion failed");
`else
`define DGCD_ASSERT_IMPLY(name, pre, post)
`define DGCD_ASSERT_NEXT(name, pre, post)
`endif
`endif

### design/dgcd_pkg.sv
// Shared constants, types and microcode table of the cycle detect unit.
package dgcd_pkg;

    localparam int MAX_NODES = 32;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int CMD_W     = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_CHECK  = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    typedef logic [2:0] step_t;

    localparam step_t S_IDLE = 3'd0;
    localparam step_t S_ROOT = 3'd1;
    localparam step_t S_PUSH = 3'd2;
    localparam step_t S_SCAN = 3'd3;
    localparam step_t S_EXIT = 3'd4;
    localparam step_t S_DONE = 3'd5;
    localparam step_t S_RET  = 3'd6;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_DISPATCH,
        OP_PUSH_ROOT,
        OP_SCAN,
        OP_DELIVER
    } op_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_START,
        C_ROOT_DONE,
        C_ROOT_SEEN,
        C_SCAN_EXIT,
        C_FOUND,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        logic  invert;
        step_t target;
    } ctl_word_t;

    // Control store: jump to target when (cond ^ invert), else advance by one.
    function automatic ctl_word_t ucode(input step_t step);
        ctl_word_t w;
        case (step)
            S_IDLE:  w = '{op: OP_DISPATCH,  cond: C_START,     invert: 1'b1, target: S_IDLE};
            S_ROOT:  w = '{op: OP_NOP,       cond: C_ROOT_DONE, invert: 1'b0, target: S_DONE};
            S_PUSH:  w = '{op: OP_PUSH_ROOT, cond: C_ROOT_SEEN, invert: 1'b0, target: S_ROOT};
            S_SCAN:  w = '{op: OP_SCAN,      cond: C_SCAN_EXIT, invert: 1'b1, target: S_SCAN};
            S_EXIT:  w = '{op: OP_NOP,       cond: C_FOUND,     invert: 1'b1, target: S_ROOT};
            S_DONE:  w = '{op: OP_DELIVER,   cond: C_OUT_BUSY,  invert: 1'b0, target: S_DONE};
            S_RET:   w = '{op: OP_NOP,       cond: C_ALWAYS,    invert: 1'b0, target: S_IDLE};
            default: w = '{op: OP_NOP,       cond: C_ALWAYS,    invert: 1'b0, target: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

### design/dgcd_cmd_if.sv
// Command channel: valid/ready handshake carrying one command item.
interface dgcd_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [dgcd_pkg::CMD_W-1:0]  command;
    logic [dgcd_pkg::NODE_W-1:0] src_node;
    logic [dgcd_pkg::NODE_W-1:0] dst_node;

    modport source (output valid, output command, output src_node, output dst_node,
                    input ready);
    modport sink   (input valid, input command, input src_node, input dst_node,
                    output ready);
endinterface

### design/dgcd_res_if.sv
// Result channel: valid/ready handshake carrying one cycle check answer.
interface dgcd_res_if;
    logic valid;
    logic ready;
    logic has_cycle;

    modport source (output valid, output has_cycle, input ready);
    modport sink   (input valid, input has_cycle, output ready);
endinterface

### design/directed_graph_cycle_detect_unit.sv
// Directed graph cycle detect unit: adjacency matrix with a microcoded DFS check.
// After a clear or add item the next item is taken in the following cycle.
// During a check, the scan step of the control store walks one matrix bit of the current
// node per cycle.
// A check may start while the previous answer still waits in the output register; it then
// holds in its deliver step until that answer is taken.
// Reset (rst_n low, asynchronous) empties the graph and sets node_count to 0 at once.
`include "directed_graph_cycle_detect_unit_macros.svh"

module directed_graph_cycle_detect_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [dgcd_pkg::CNT_W-1:0] cfg_wdata,
    dgcd_cmd_if.sink                   cmd,
    dgcd_res_if.source                 res
);

    localparam int MAX_NODES = dgcd_pkg::MAX_NODES;
    localparam int NODE_W    = dgcd_pkg::NODE_W;
    localparam int CNT_W     = dgcd_pkg::CNT_W;

    // Configuration and sequencer
    logic [CNT_W-1:0]      node_count_reg;
    logic [CNT_W-1:0]      n_eff;
    dgcd_pkg::step_t       upc_reg;
    dgcd_pkg::step_t       upc_next;
    dgcd_pkg::ctl_word_t   ctl;
    logic                  cond_val;

    // Graph storage: one row per source node, a row reads as zero until written
    logic [MAX_NODES-1:0]  row_mem [MAX_NODES];
    logic [MAX_NODES-1:0]  row_valid_reg;

    // Search state
    logic [MAX_NODES-1:0]  visited_reg;
    logic [MAX_NODES-1:0]  onstk_reg;
    logic [CNT_W-1:0]      root_reg;
    logic [CNT_W-1:0]      depth_reg;
    logic [NODE_W-1:0]     cur_v_reg;
    logic [CNT_W-1:0]      cur_i_reg;
    logic [MAX_NODES-1:0]  cur_row_reg;
    logic [NODE_W-1:0]     stk_v_mem [MAX_NODES];
    logic [CNT_W-1:0]      stk_i_mem [MAX_NODES];
    logic                  found_reg;

    // Output register
    logic                  out_valid_reg;
    logic                  has_cycle_reg;

    // Datapath terms
    logic                  cmd_fire;
    logic                  add_ok;
    logic [NODE_W-1:0]     root_idx;
    logic [MAX_NODES-1:0]  cur_row;
    logic                  scan_in_range;
    logic [NODE_W-1:0]     scan_node;
    logic                  edge_hit;
    logic                  back_hit;
    logic                  fwd_push;
    logic                  scan_exit;
    logic [NODE_W-1:0]     stk_wr_idx;
    logic [NODE_W-1:0]     stk_rd_idx;
    logic                  out_busy;

    // Clamp node count to the matrix size
    assign n_eff = (node_count_reg > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_reg;

    // Fetch the control word of the current step
    assign ctl = dgcd_pkg::ucode(upc_reg);

    assign cmd.ready  = (ctl.op == dgcd_pkg::OP_DISPATCH);
    assign cmd_fire   = cmd.valid && cmd.ready;
    assign add_ok     = (CNT_W'(cmd.src_node) < n_eff) && (CNT_W'(cmd.dst_node) < n_eff);

    assign res.valid     = out_valid_reg;
    assign res.has_cycle = has_cycle_reg;
    assign out_busy      = out_valid_reg && !res.ready;

    // Scan the next neighbor bit of the node on top of the stack
    assign root_idx      = root_reg[NODE_W-1:0];
    assign cur_row       = cur_row_reg;
    assign scan_in_range = cur_i_reg < n_eff;
    assign scan_node     = cur_i_reg[NODE_W-1:0];
    assign edge_hit      = scan_in_range && cur_row[scan_node];
    assign back_hit      = edge_hit && onstk_reg[scan_node];
    assign fwd_push      = edge_hit && !onstk_reg[scan_node] && !visited_reg[scan_node];
    assign scan_exit     = (!scan_in_range && (depth_reg == CNT_W'(1))) || back_hit;
    assign stk_wr_idx    = NODE_W'(depth_reg - CNT_W'(1));
    assign stk_rd_idx    = NODE_W'(depth_reg - CNT_W'(2));

    // Select the jump condition
    always_comb
    begin
        case (ctl.cond)
            dgcd_pkg::C_ALWAYS:    cond_val = 1'b1;
            dgcd_pkg::C_START:     cond_val = cmd_fire && (cmd.command == dgcd_pkg::CMD_CHECK);
            dgcd_pkg::C_ROOT_DONE: cond_val = root_reg >= n_eff;
            dgcd_pkg::C_ROOT_SEEN: cond_val = visited_reg[root_idx];
            dgcd_pkg::C_SCAN_EXIT: cond_val = scan_exit;
            dgcd_pkg::C_FOUND:     cond_val = found_reg;
            dgcd_pkg::C_OUT_BUSY:  cond_val = out_busy;
            default:               cond_val = 1'b0;
        endcase
    end

    // Jump or advance the step counter
    assign upc_next = (cond_val ^ ctl.invert) ? ctl.target : dgcd_pkg::step_t'(upc_reg + 3'd1);

    // Control state: sequencer, marks, counters, valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= '0;
            upc_reg        <= dgcd_pkg::S_IDLE;
            row_valid_reg  <= '0;
            visited_reg    <= '0;
            onstk_reg      <= '0;
            root_reg       <= '0;
            depth_reg      <= '0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
            upc_reg <= upc_next;
            // Drop the taken answer unless the deliver step reloads the register
            if (res.valid && res.ready && (ctl.op != dgcd_pkg::OP_DELIVER))
            begin
                out_valid_reg <= 1'b0;
            end
            case (ctl.op)
                dgcd_pkg::OP_DISPATCH:
                begin
                    if (cmd_fire)
                    begin
                        case (cmd.command)
                            dgcd_pkg::CMD_CLEAR:
                            begin
                                row_valid_reg <= '0;
                            end
                            dgcd_pkg::CMD_ADD:
                            begin
                                if (add_ok)
                                begin
                                    row_valid_reg[cmd.src_node] <= 1'b1;
                                end
                            end
                            dgcd_pkg::CMD_CHECK:
                            begin
                                visited_reg <= '0;
                                onstk_reg   <= '0;
                                root_reg    <= '0;
                                depth_reg   <= '0;
                                found_reg   <= 1'b0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                dgcd_pkg::OP_PUSH_ROOT:
                begin
                    if (!visited_reg[root_idx])
                    begin
                        visited_reg[root_idx] <= 1'b1;
                        onstk_reg[root_idx]   <= 1'b1;
                        depth_reg             <= CNT_W'(1);
                    end
                    root_reg <= root_reg + CNT_W'(1);
                end
                dgcd_pkg::OP_SCAN:
                begin
                    if (!scan_in_range)
                    begin
                        onstk_reg[cur_v_reg] <= 1'b0;
                        depth_reg            <= depth_reg - CNT_W'(1);
                    end
                    else if (back_hit)
                    begin
                        found_reg <= 1'b1;
                    end
                    else if (fwd_push)
                    begin
                        visited_reg[scan_node] <= 1'b1;
                        onstk_reg[scan_node]   <= 1'b1;
                        depth_reg              <= depth_reg + CNT_W'(1);
                    end
                end
                dgcd_pkg::OP_DELIVER:
                begin
                    if (!out_busy)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload: matrix rows, walk stack, top of stack, answer
    always_ff @(posedge clk)
    begin
        case (ctl.op)
            dgcd_pkg::OP_DISPATCH:
            begin
                if (cmd_fire && (cmd.command == dgcd_pkg::CMD_ADD) && add_ok)
                begin
                    row_mem[cmd.src_node] <=
                        (row_valid_reg[cmd.src_node] ? row_mem[cmd.src_node] : '0)
                        | (MAX_NODES'(1) << cmd.dst_node);
                end
            end
            dgcd_pkg::OP_PUSH_ROOT:
            begin
                if (!visited_reg[root_idx])
                begin
                    cur_v_reg   <= root_idx;
                    cur_i_reg   <= '0;
                    cur_row_reg <= row_valid_reg[root_idx] ? row_mem[root_idx] : '0;
                end
            end
            dgcd_pkg::OP_SCAN:
            begin
                if (!scan_in_range)
                begin
                    // Pop: restore the parent from the stack
                    if (depth_reg > CNT_W'(1))
                    begin
                        cur_v_reg   <= stk_v_mem[stk_rd_idx];
                        cur_i_reg   <= stk_i_mem[stk_rd_idx];
                        cur_row_reg <= row_valid_reg[stk_v_mem[stk_rd_idx]]
                                       ? row_mem[stk_v_mem[stk_rd_idx]] : '0;
                    end
                end
                else
                begin
                    cur_i_reg <= cur_i_reg + CNT_W'(1);
                    if (fwd_push)
                    begin
                        // Push: save the parent with its next neighbor index
                        stk_v_mem[stk_wr_idx] <= cur_v_reg;
                        stk_i_mem[stk_wr_idx] <= cur_i_reg + CNT_W'(1);
                        cur_v_reg             <= scan_node;
                        cur_i_reg             <= '0;
                        cur_row_reg           <= row_valid_reg[scan_node]
                                                 ? row_mem[scan_node] : '0;
                    end
                end
            end
            dgcd_pkg::OP_DELIVER:
            begin
                if (!out_busy)
                begin
                    has_cycle_reg <= found_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Checks on the search and sequencer
    `DGCD_ASSERT_NEXT(a_check_start, cmd_fire && (cmd.command == dgcd_pkg::CMD_CHECK), (upc_reg == dgcd_pkg::S_ROOT) && (depth_reg == '0) && !found_reg)
    `DGCD_ASSERT_IMPLY(a_scan_depth, upc_reg == dgcd_pkg::S_SCAN, depth_reg != '0)
    `DGCD_ASSERT_IMPLY(a_onstk_visited, 1'b1, (onstk_reg & ~visited_reg) == '0)
    `DGCD_ASSERT_NEXT(a_deliver, (upc_reg == dgcd_pkg::S_DONE) && !out_busy, res.valid && (res.has_cycle == $past(found_reg)))

endmodule
